>>> rtl/core/ppv_pkg.sv
`default_nettype none
package ppv_pkg;

   localparam int DATA_W  = 32;
   localparam int SIZE_W  = 14;
   localparam int QUOT_W  = 38;
   localparam int CSR_W   = 64;
   localparam int INDEX_W = 4;
   localparam int SUM_W   = 40;

   localparam logic [INDEX_W-1:0] REG_ROW_X_XY     = 4'd0;
   localparam logic [INDEX_W-1:0] REG_ROW_X_ZW     = 4'd1;
   localparam logic [INDEX_W-1:0] REG_ROW_Y_XY     = 4'd2;
   localparam logic [INDEX_W-1:0] REG_ROW_Y_ZW     = 4'd3;
   localparam logic [INDEX_W-1:0] REG_ROW_W_XY     = 4'd4;
   localparam logic [INDEX_W-1:0] REG_ROW_W_ZW     = 4'd5;
   localparam logic [INDEX_W-1:0] REG_SCREEN_WIDTH = 4'd6;
   localparam logic [INDEX_W-1:0] REG_SCREEN_HEIGHT= 4'd7;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 14'd1920;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 14'd1080;

   localparam logic signed [DATA_W-1:0] PIX_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] PIX_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic valid;
      logic visible;
      logic neg_x;
      logic neg_y;
   } ctl_type;

endpackage
`default_nettype wire

>>> rtl/core/ppv_div_pipe.sv
`default_nettype none
module ppv_div_pipe import ppv_pkg::*; #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 50
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [NUM_W-1:0]  num,
   input  wire logic [DEN_W-1:0]  den,
   output logic [QUOT_W-1:0]      quot,
   output logic                   ovf
);

   logic [DEN_W-1:0]  rem_ff [0:QUOT_W];
   logic [DEN_W-1:0]  den_ff [0:QUOT_W];
   logic [QUOT_W-1:0] low_ff [0:QUOT_W];
   logic [QUOT_W-1:0] q_ff   [0:QUOT_W];
   logic              ovf_ff [0:QUOT_W];
   logic [DEN_W-1:0]  top_in;

   // top part of the numerator; below the divisor unless the quotient overflows
   assign top_in = DEN_W'(num[NUM_W-1:QUOT_W]);

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff[0] <= (DEN_W'(num[NUM_W-1:QUOT_W]) >= den) ||
                      ((NUM_W - QUOT_W) > DEN_W && (num >> (QUOT_W + DEN_W)) != '0);
         rem_ff[0] <= top_in;
         den_ff[0] <= den;
         low_ff[0] <= num[QUOT_W-1:0];
         q_ff[0]   <= '0;
      end
   end

   for (genvar k = 1; k <= QUOT_W; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic           take;
      assign trial = {rem_ff[k-1], low_ff[k-1][QUOT_W-k]};
      assign take  = trial >= {1'b0, den_ff[k-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= take ? DEN_W'(trial - {1'b0, den_ff[k-1]}) : DEN_W'(trial);
            den_ff[k] <= den_ff[k-1];
            low_ff[k] <= low_ff[k-1];
            q_ff[k]   <= {q_ff[k-1][QUOT_W-2:0], take};
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quot = q_ff[QUOT_W];
   assign ovf  = ovf_ff[QUOT_W];

endmodule
`default_nettype wire

>>> rtl/core/perspective_project_viewport_unit.sv
`default_nettype none
// Pipeline: three front stages, the 39 registers of each division lane and
// the output register lie between an accepted req word and its rsp word.
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while the output word waits.
// Reset: synchronous, active high; clears all valid bits, the matrix
// registers to zero and the viewport size to 1920 x 1080.
module perspective_project_viewport_unit import ppv_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [DATA_W-1:0] req_point_x,
   input  wire logic signed [DATA_W-1:0] req_point_y,
   input  wire logic signed [DATA_W-1:0] req_point_z,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_on_screen,
   output logic signed [DATA_W-1:0]      rsp_pixel_x,
   output logic signed [DATA_W-1:0]      rsp_pixel_y,
   input  wire logic                     csr_wr_en,
   input  wire logic [INDEX_W-1:0]       csr_index,
   input  wire logic [CSR_W-1:0]         csr_wdata
);

   localparam int CW      = 66 - FRAC_BITS;
   localparam int NW      = CW + SIZE_W;
   localparam int DIV_LAT = QUOT_W + 1;
   localparam int THR_RAW = ((1 << FRAC_BITS) + 500) / 1000;
   localparam int THR     = (THR_RAW < 1) ? 1 : THR_RAW;
   localparam logic signed [CW-1:0] THR_V = CW'(THR);

   // configuration
   logic [CSR_W-1:0]  row_ff [0:5];
   logic [SIZE_W-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) row_ff[i] <= '0;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_ROW_X_XY:      row_ff[0] <= csr_wdata;
            REG_ROW_X_ZW:      row_ff[1] <= csr_wdata;
            REG_ROW_Y_XY:      row_ff[2] <= csr_wdata;
            REG_ROW_Y_ZW:      row_ff[3] <= csr_wdata;
            REG_ROW_W_XY:      row_ff[4] <= csr_wdata;
            REG_ROW_W_ZW:      row_ff[5] <= csr_wdata;
            REG_SCREEN_WIDTH:  width_ff  <= csr_wdata[SIZE_W-1:0];
            REG_SCREEN_HEIGHT: height_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // stage 1: nine products, three rows by three coordinates
   logic signed [63:0] prod_ff [0:2][0:2];
   logic               v1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            prod_ff[r][0] <= $signed(row_ff[2*r][31:0])    * req_point_x;
            prod_ff[r][1] <= $signed(row_ff[2*r][63:32])   * req_point_y;
            prod_ff[r][2] <= $signed(row_ff[2*r+1][31:0])  * req_point_z;
         end
      end
   end

   // stage 2: floor-shift and sum each row
   logic signed [CW-1:0] clip_ff [0:2];
   logic                 v2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            clip_ff[r] <= CW'(prod_ff[r][0] >>> FRAC_BITS) + CW'(prod_ff[r][1] >>> FRAC_BITS)
                        + CW'(prod_ff[r][2] >>> FRAC_BITS)
                        + CW'($signed(row_ff[2*r+1][63:32]));
         end
      end
   end

   // stage 3: visibility, magnitudes scaled by the viewport size
   logic [CW-1:0] mag_x, mag_y;
   logic [NW-1:0] num_x_ff, num_y_ff;
   logic [CW-1:0] den_ff;
   ctl_type       ctl3_ff;

   assign mag_x = clip_ff[0][CW-1] ? CW'(-clip_ff[0]) : CW'(clip_ff[0]);
   assign mag_y = clip_ff[1][CW-1] ? CW'(-clip_ff[1]) : CW'(clip_ff[1]);

   always_ff @(posedge clock) begin
      if (adv) begin
         num_x_ff <= NW'(mag_x) * NW'(width_ff);
         num_y_ff <= NW'(mag_y) * NW'(height_ff);
         den_ff   <= {clip_ff[2][CW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         ctl3_ff.valid <= 1'b0;
      end else if (adv) begin
         v1_ff           <= req_valid;
         v2_ff           <= v1_ff;
         ctl3_ff.valid   <= v2_ff;
         ctl3_ff.visible <= clip_ff[2] >= THR_V;
         ctl3_ff.neg_x   <= clip_ff[0][CW-1];
         ctl3_ff.neg_y   <= clip_ff[1][CW-1];
      end
   end

   // division lanes, control travels alongside
   logic [QUOT_W-1:0] q_x, q_y;
   logic              ovf_x, ovf_y;

   ppv_div_pipe #(.NUM_W(NW), .DEN_W(CW)) u_div_x (
      .clock (clock), .en (adv), .num (num_x_ff), .den (den_ff),
      .quot (q_x), .ovf (ovf_x)
   );

   ppv_div_pipe #(.NUM_W(NW), .DEN_W(CW)) u_div_y (
      .clock (clock), .en (adv), .num (num_y_ff), .den (den_ff),
      .quot (q_y), .ovf (ovf_y)
   );

   ctl_type ctl_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) ctl_ff[i] <= '0;
      end else if (adv) begin
         ctl_ff[0] <= ctl3_ff;
         for (int i = 1; i < DIV_LAT; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   // output stage: center offset and saturate
   ctl_type                 ctl_o;
   logic signed [SUM_W-1:0] base_x, base_y, off_x, off_y, sum_x, sum_y;
   logic signed [DATA_W-1:0] pix_x_in, pix_y_in;
   logic signed [DATA_W-1:0] pix_x_ff, pix_y_ff;
   logic                     on_ff;

   assign ctl_o  = ctl_ff[DIV_LAT-1];
   assign base_x = SUM_W'({width_ff, {(FRAC_BITS-1){1'b0}}});
   assign base_y = SUM_W'({height_ff, {(FRAC_BITS-1){1'b0}}});
   assign off_x  = ctl_o.neg_x ? -SUM_W'(q_x) : SUM_W'(q_x);
   assign off_y  = ctl_o.neg_y ? -SUM_W'(q_y) : SUM_W'(q_y);
   assign sum_x  = base_x + off_x;
   assign sum_y  = base_y - off_y;

   always_comb begin
      priority if (!ctl_o.visible) pix_x_in = '0;
      else if (ovf_x)              pix_x_in = ctl_o.neg_x ? PIX_MIN : PIX_MAX;
      else if (sum_x > SUM_W'(PIX_MAX)) pix_x_in = PIX_MAX;
      else if (sum_x < SUM_W'(PIX_MIN)) pix_x_in = PIX_MIN;
      else                         pix_x_in = DATA_W'(sum_x);

      priority if (!ctl_o.visible) pix_y_in = '0;
      else if (ovf_y)              pix_y_in = ctl_o.neg_y ? PIX_MAX : PIX_MIN;
      else if (sum_y > SUM_W'(PIX_MAX)) pix_y_in = PIX_MAX;
      else if (sum_y < SUM_W'(PIX_MIN)) pix_y_in = PIX_MIN;
      else                         pix_y_in = DATA_W'(sum_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ctl_o.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         on_ff    <= ctl_o.visible;
         pix_x_ff <= pix_x_in;
         pix_y_ff <= pix_y_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_on_screen = on_ff;
   assign rsp_pixel_x   = pix_x_ff;
   assign rsp_pixel_y   = pix_y_ff;

`ifndef SYNTH
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_on_screen |-> rsp_pixel_x == 0 && rsp_pixel_y == 0)
      else $error("hidden point with nonzero pixel");

   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready disagrees with output stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(ctl_o) && $stable(q_x) && $stable(q_y))
      else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps
module testbench;
   import ppv_pkg::*;

   localparam int FRAC = 16;
   localparam longint ONE = 64'sd65536;
   localparam longint VIS_MIN = 66;
   localparam longint QCAP = 64'sd1 << 40;
   localparam int DRAIN = 45;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [INDEX_W-1:0] REG_UNUSED = 4'd15;

   typedef struct {
      logic signed [DATA_W-1:0] x, y, z;
   } point_word;

   typedef struct {
      logic                     on_screen;
      logic signed [DATA_W-1:0] px, py;
   } pixel_word;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic signed [DATA_W-1:0] req_point_x = 0, req_point_y = 0, req_point_z = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic rsp_on_screen;
   logic signed [DATA_W-1:0] rsp_pixel_x, rsp_pixel_y;
   logic csr_wr_en = 0;
   logic [INDEX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   perspective_project_viewport_unit #(.FRAC_BITS(FRAC)) dut (.*);

   always #5 clock = ~clock;

   // shadow copy of the registers
   logic [63:0] matrix_reg [6];
   logic [SIZE_W-1:0] view_w = WIDTH_RESET, view_h = HEIGHT_RESET;

   point_word pending_points [$];
   pixel_word pixel_q [$];
   int errors = 0, checked = 0, visible_seen = 0, clipped_seen = 0;
   int cycles = 0, burst_left = 0, gap_left = 0;

   initial foreach (matrix_reg[i]) matrix_reg[i] = '0;

   function automatic longint row_dot(logic [63:0] xy, logic [63:0] zw,
                                      longint px, longint py, longint pz);
      longint a, b, c;
      a = longint'($signed(xy[31:0])) * px;
      b = longint'($signed(xy[63:32])) * py;
      c = longint'($signed(zw[31:0])) * pz;
      return (a >>> FRAC) + (b >>> FRAC) + (c >>> FRAC) + longint'($signed(zw[63:32]));
   endfunction

   // |c| * size / d truncated, capped, sign of c restored
   function automatic longint viewport_offset(longint c, logic [SIZE_W-1:0] size,
                                              longint d);
      logic [127:0] num, quo;
      logic [63:0] mag;
      longint q;
      mag = (c < 0) ? -c : c;
      num = 128'(mag) * 128'(size);
      quo = num / 128'(d);
      q = (quo > 128'(QCAP)) ? QCAP : longint'(quo);
      return (c < 0) ? -q : q;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return PIX_MAX;
      if (v < -64'sd2147483648) return PIX_MIN;
      return v[31:0];
   endfunction

   function automatic pixel_word project_point(point_word p);
      pixel_word r;
      longint w, cx, cy, px, py, pz;
      px = p.x; py = p.y; pz = p.z;
      w = row_dot(matrix_reg[REG_ROW_W_XY], matrix_reg[REG_ROW_W_ZW], px, py, pz);
      if (w < VIS_MIN) begin
         r.on_screen = 0; r.px = 0; r.py = 0;
         return r;
      end
      cx = row_dot(matrix_reg[REG_ROW_X_XY], matrix_reg[REG_ROW_X_ZW], px, py, pz);
      cy = row_dot(matrix_reg[REG_ROW_Y_XY], matrix_reg[REG_ROW_Y_ZW], px, py, pz);
      r.on_screen = 1;
      r.px = clamp32((longint'(view_w) << (FRAC - 1)) + viewport_offset(cx, view_w, 2 * w));
      r.py = clamp32((longint'(view_h) << (FRAC - 1)) - viewport_offset(cy, view_h, 2 * w));
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("ERROR %0t: %s got %0d, want %0d", $realtime, what, got, want);
   endtask

   // sender: bursts with random gaps, payload held until accepted
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("perspective_project_viewport_unit: mismatch");
         $finish;
      end
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && req_ready) begin
            pixel_q.push_back(project_point(pending_points[0]));
            void'(pending_points.pop_front());
         end
         if (req_valid && !req_ready) begin
            // hold the word
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 0;
         end else if (pending_points.size() > 0) begin
            req_valid <= 1;
            req_point_x <= pending_points[0].x;
            req_point_y <= pending_points[0].y;
            req_point_z <= pending_points[0].z;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            end
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver: stall pattern changes with bits 9 and 10 of the cycle count
   always @(posedge clock) begin
      pixel_word want;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pixel_q.size() == 0) begin
               errors++;
               $display("ERROR %0t: unexpected result word", $realtime);
            end else begin
               want = pixel_q.pop_front();
               checked++;
               if (want.on_screen) visible_seen++; else clipped_seen++;
               if (rsp_on_screen !== want.on_screen)
                  report_mismatch("on_screen", rsp_on_screen, want.on_screen);
               if (rsp_pixel_x !== want.px) report_mismatch("pixel_x", rsp_pixel_x, want.px);
               if (rsp_pixel_y !== want.py) report_mismatch("pixel_y", rsp_pixel_y, want.py);
            end
         end
         case ((cycles >> 9) & 3)
            0: rsp_ready <= 1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ((cycles % 13) < 9);
         endcase
      end
   end

   task automatic csr_write(logic [INDEX_W-1:0] idx, logic [63:0] value);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx < 6) matrix_reg[idx] = value;
      else if (idx == REG_SCREEN_WIDTH) view_w = value[SIZE_W-1:0];
      else if (idx == REG_SCREEN_HEIGHT) view_h = value[SIZE_W-1:0];
   endtask

   task automatic csr_done();
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic wait_idle();
      while (pending_points.size() > 0 || req_valid || pixel_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   function automatic logic [31:0] small_fix(int range);
      return 32'($signed($urandom_range(0, 2 * range)) - range);
   endfunction

   function automatic logic [63:0] pack2(logic [31:0] lo, logic [31:0] hi);
      return {hi, lo};
   endfunction

   task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      point_word p;
      p.x = x; p.y = y; p.z = z;
      pending_points.push_back(p);
   endtask

   task automatic random_config(bit wild);
      logic [31:0] wz;
      wz = 32'(ONE) + small_fix(16384);
      for (int r = 0; r < 4; r++)
         csr_write(INDEX_W'(r), wild && $urandom_range(0, 1) ?
                   {$urandom(), $urandom()} :
                   pack2(small_fix(4 * ONE), small_fix(4 * ONE)));
      csr_write(REG_ROW_W_XY, wild ? {$urandom(), $urandom()}
                                   : pack2(small_fix(ONE / 4), small_fix(ONE / 4)));
      csr_write(REG_ROW_W_ZW, pack2(wz, small_fix(ONE)));
      case ($urandom_range(0, 5))
         0: csr_write(REG_SCREEN_WIDTH, 1);
         1: csr_write(REG_SCREEN_WIDTH, 8192);
         default: csr_write(REG_SCREEN_WIDTH, $urandom_range(1, 8192));
      endcase
      case ($urandom_range(0, 5))
         0: csr_write(REG_SCREEN_HEIGHT, 1);
         1: csr_write(REG_SCREEN_HEIGHT, 8192);
         default: csr_write(REG_SCREEN_HEIGHT, $urandom_range(1, 8192));
      endcase
      csr_done();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;

      // identity projection, reset viewport: threshold edges and saturation
      csr_write(REG_ROW_X_XY, pack2(32'(ONE), 0));
      csr_write(REG_ROW_Y_XY, pack2(0, 32'(ONE)));
      csr_write(REG_ROW_W_ZW, pack2(32'(ONE), 0));
      csr_done();
      add_point(0, 0, 32'(ONE));
      add_point(0, 0, 0);
      add_point(0, 0, 65);
      add_point(0, 0, 66);
      add_point(0, 0, -32'(ONE));
      add_point(32'h7fffffff, 32'h80000000, 66);
      add_point(32'h80000000, 32'h7fffffff, 32'(ONE));
      add_point(32'(ONE), -32'(ONE), 32'(ONE));
      add_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      add_point(32'h80000000, 32'h80000000, 32'h80000000);
      add_point(1, -1, 66);
      wait_idle();

      // extreme matrix entries, extreme and zero viewport, ignored index
      csr_write(REG_ROW_X_XY, 64'h7fffffff_80000000);
      csr_write(REG_ROW_X_ZW, 64'h80000000_7fffffff);
      csr_write(REG_ROW_Y_XY, 64'h80000000_80000000);
      csr_write(REG_ROW_Y_ZW, 64'h7fffffff_7fffffff);
      csr_write(REG_ROW_W_XY, 64'h0);
      csr_write(REG_ROW_W_ZW, 64'h7fffffff_00010000);
      csr_write(REG_SCREEN_WIDTH, 8192);
      csr_write(REG_SCREEN_HEIGHT, 0);
      csr_write(REG_UNUSED, 64'hffffffff_ffffffff);
      csr_done();
      add_point(32'h7fffffff, 32'h80000000, 32'h80000000);
      add_point(32'h80000000, 32'h7fffffff, 32'h7fffffff);
      add_point(0, 0, 0);
      add_point(32'(ONE), 32'(ONE), 32'(ONE));
      wait_idle();
      csr_write(REG_SCREEN_WIDTH, 1);
      csr_write(REG_SCREEN_HEIGHT, 8192);
      csr_done();
      wait_idle();
      add_point(32'h7fffffff, 32'h80000000, 32'h80000000);
      add_point(-32'(ONE), 32'(ONE), 0);
      add_point(5, 7, 32'h80000000);
      wait_idle();

      // random phases: mostly points in front of the viewer, some noise
      for (int ph = 0; ph < 8; ph++) begin
         random_config(ph % 3 == 2);
         for (int i = 0; i < 235; i++) begin
            if ($urandom_range(0, 99) < 85)
               add_point(small_fix(64 * ONE), small_fix(64 * ONE),
                         32'($urandom_range(ONE / 16, 64 * ONE)));
            else
               add_point($urandom(), $urandom(), $urandom());
         end
         wait_idle();
      end

      $display("checked %0d result words: %0d on screen, %0d clipped", checked,
               visible_seen, clipped_seen);
      if (errors == 0)
         $display("perspective_project_viewport_unit: match");
      else
         $display("perspective_project_viewport_unit: mismatch");
      $finish;
   end

endmodule
